// ===== hdl/git_delta_instruction_decoder_top_defines.svh =====
// assertion macros for the delta decoder
`ifndef GIT_DELTA_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define GIT_DELTA_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GDD_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gdd implication failed");

// next-cycle implication, sampled on clk, off during reset
`define GDD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gdd next-cycle check failed");

`endif

// ===== hdl/gdd_pkg.sv =====
// types, constants and helpers shared by the delta decoder
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int SHIFT_W    = $clog2(SIZE_BITS + 8);
    localparam int CMP_W      = (SIZE_BITS > 32) ? SIZE_BITS : 32;
    localparam int PROD_W     = SIZE_BITS + 1;
    localparam int OFF_W      = 32;
    localparam int LEN_W      = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [SHIFT_W-1:0] SHIFT_STEP  = SHIFT_W'(7);
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(SIZE_BITS);
    localparam logic [LEN_W-1:0]   LEN_ZERO_AS = LEN_W'(32'h1_0000);

    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_SRC_SIZE   = 3'd1;
    localparam logic [2:0] ERR_COPY_RANGE = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
    localparam logic [2:0] ERR_OPCODE_0   = 3'd4;
    localparam logic [2:0] ERR_TGT_SIZE   = 3'd5;
    localparam logic [2:0] ERR_VARINT_LEN = 3'd6;

    typedef enum logic [2:0] {
        PH_SRC,
        PH_TGT,
        PH_OP,
        PH_ARGS,
        PH_LIT,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       literal_byte;
        logic [OFF_W-1:0] copy_offset;
        logic [LEN_W-1:0] copy_length;
        logic [2:0]       error_code;
        logic             last;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               space;
    } fifo_stat_t;

    function automatic result_t mk_err(input logic [2:0] code, input logic fin);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERR;
        r.error_code = code;
        r.last       = fin;
        return r;
    endfunction

    function automatic result_t mk_done();
        result_t r;
        r      = '0;
        r.kind = KIND_DONE;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_lit(input logic [7:0] b);
        result_t r;
        r              = '0;
        r.kind         = KIND_LIT;
        r.literal_byte = b;
        return r;
    endfunction

    function automatic result_t mk_copy(input logic [OFF_W-1:0] off,
                                        input logic [LEN_W-1:0] len);
        result_t r;
        r             = '0;
        r.kind        = KIND_COPY;
        r.copy_offset = off;
        r.copy_length = len;
        return r;
    endfunction

endpackage

// ===== hdl/gdd_result_fifo.sv =====
// four-entry result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps

module gdd_result_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  gdd_pkg::push_t      push,
    output gdd_pkg::fifo_stat_t stat,
    output logic                out_valid,
    input  logic                out_ready,
    output gdd_pkg::result_t    head
);

    gdd_pkg::result_t mem [gdd_pkg::FIFO_DEPTH];

    logic [gdd_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [gdd_pkg::FIFO_AW-1:0] wr_ptr_next;
    logic [gdd_pkg::FIFO_AW-1:0] wr_ptr_inc;
    logic [gdd_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [gdd_pkg::FIFO_AW-1:0] rd_ptr_next;
    logic [gdd_pkg::FIFO_CW-1:0] count_reg;
    logic [gdd_pkg::FIFO_CW-1:0] count_next;
    logic                        pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    assign stat.count = count_reg;
    assign stat.space = (count_reg <= gdd_pkg::FIFO_CW'(gdd_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + gdd_pkg::FIFO_AW'(push.n);
        rd_ptr_next = rd_ptr_reg + gdd_pkg::FIFO_AW'(pop);
        count_next  = count_reg + gdd_pkg::FIFO_CW'(push.n) - gdd_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/gdd_core.sv =====
// input register, stream state and the per-byte decode step
`timescale 1ns / 1ps

module gdd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [31:0]         base_size,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          delta_byte,
    input  logic                last_byte,
    input  gdd_pkg::fifo_stat_t fifo_stat,
    output gdd_pkg::push_t      push
);

    // input register
    logic       item_valid_reg;
    logic       item_valid_next;
    logic [7:0] byte_reg;
    logic       last_in_reg;
    logic       fire;

    logic [31:0] base_size_reg;

    gdd_pkg::phase_t                 phase_reg,    phase_next;
    logic [gdd_pkg::SIZE_BITS-1:0]   varint_reg,   varint_next;
    logic [gdd_pkg::SHIFT_W-1:0]     shift_reg,    shift_next;
    logic [gdd_pkg::SIZE_BITS-1:0]   target_reg,   target_next;
    logic [gdd_pkg::PROD_W-1:0]      produced_reg, produced_next;
    logic [6:0]                      pend_reg,     pend_next;
    logic [gdd_pkg::OFF_W-1:0]       off_reg,      off_next;
    logic [gdd_pkg::LEN_W-1:0]       len_reg,      len_next;
    logic [6:0]                      lit_rem_reg,  lit_rem_next;
    logic [2:0]                      err_code_reg, err_code_next;

    // decode helpers
    logic [7:0]                          c;
    logic                                fin;
    logic [gdd_pkg::SIZE_BITS+6:0]       ext;
    logic                                vint_over;
    logic [gdd_pkg::SIZE_BITS-1:0]       vnew;
    logic [gdd_pkg::CMP_W-1:0]           cmp_val;
    logic [gdd_pkg::CMP_W-1:0]           cmp_base;
    logic [6:0]                          sel;
    logic [6:0]                          pend_upd;
    logic [gdd_pkg::OFF_W-1:0]           off_upd;
    logic [gdd_pkg::LEN_W-1:0]           len_upd;
    logic [gdd_pkg::OFF_W-1:0]           cc_off;
    logic [gdd_pkg::LEN_W-1:0]           cc_lacc;
    logic [gdd_pkg::LEN_W-1:0]           cc_len;
    logic [gdd_pkg::OFF_W:0]             cc_end;
    logic                                cc_beyond;
    logic [gdd_pkg::PROD_W:0]            sum_copy;
    logic [gdd_pkg::PROD_W:0]            sum_lit;
    logic [gdd_pkg::PROD_W-1:0]          prod_copy;
    logic [gdd_pkg::PROD_W-1:0]          prod_lit;
    logic [gdd_pkg::PROD_W-1:0]          target_ext;
    logic [gdd_pkg::PROD_W-1:0]          vnew_ext;

    assign fire     = item_valid_reg && fifo_stat.space;
    assign in_ready = !item_valid_reg || fire;
    assign c        = byte_reg;
    assign fin      = last_in_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    // size number byte
    always_comb
    begin
        ext       = '0;
        ext[6:0]  = c[6:0];
        ext       = ext << shift_reg;
        vint_over = (shift_reg >= gdd_pkg::SHIFT_LIMIT) ||
                    (|ext[gdd_pkg::SIZE_BITS+6:gdd_pkg::SIZE_BITS]);
        vnew      = varint_reg | ext[gdd_pkg::SIZE_BITS-1:0];
        cmp_val   = '0;
        cmp_val[gdd_pkg::SIZE_BITS-1:0] = vnew;
        cmp_base  = '0;
        cmp_base[31:0] = base_size_reg;
        vnew_ext  = '0;
        vnew_ext[gdd_pkg::SIZE_BITS-1:0] = vnew;
    end

    // copy argument gather: lowest pending select bit takes this byte
    always_comb
    begin
        sel      = pend_reg & (~pend_reg + 7'd1);
        pend_upd = pend_reg & ~sel;
        off_upd  = off_reg;
        len_upd  = len_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (sel[i])
            begin
                off_upd[8*i +: 8] = c;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (sel[4+i])
            begin
                len_upd[8*i +: 8] = c;
            end
        end
    end

    // copy range check and produced-count updates
    always_comb
    begin
        if (phase_reg == gdd_pkg::PH_ARGS)
        begin
            cc_off  = off_upd;
            cc_lacc = len_upd;
        end
        else
        begin
            cc_off  = '0;
            cc_lacc = '0;
        end
        cc_len    = (cc_lacc == '0) ? gdd_pkg::LEN_ZERO_AS : cc_lacc;
        cc_end    = {1'b0, cc_off} + {9'b0, cc_len};
        cc_beyond = cc_end > {1'b0, base_size_reg};

        sum_copy  = {1'b0, produced_reg} +
                    {{(gdd_pkg::PROD_W + 1 - gdd_pkg::LEN_W){1'b0}}, cc_len};
        sum_lit   = {1'b0, produced_reg} + {{gdd_pkg::PROD_W{1'b0}}, 1'b1};
        prod_copy = sum_copy[gdd_pkg::PROD_W] ? '1 : sum_copy[gdd_pkg::PROD_W-1:0];
        prod_lit  = sum_lit[gdd_pkg::PROD_W]  ? '1 : sum_lit[gdd_pkg::PROD_W-1:0];

        target_ext = {1'b0, target_reg};
    end

    // decode step for the byte in the input register
    always_comb
    begin
        logic do_copy;
        logic restart;
        logic hold_err;
        logic [2:0] hold_code;

        do_copy       = 1'b0;
        restart       = 1'b0;
        hold_err      = 1'b0;
        hold_code     = gdd_pkg::ERR_NONE;
        push          = '0;
        phase_next    = phase_reg;
        varint_next   = varint_reg;
        shift_next    = shift_reg;
        target_next   = target_reg;
        produced_next = produced_reg;
        pend_next     = pend_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        lit_rem_next  = lit_rem_reg;
        err_code_next = err_code_reg;

        case (phase_reg)
            gdd_pkg::PH_SRC,
            gdd_pkg::PH_TGT:
            begin
                if (vint_over)
                begin
                    push.n    = 2'd1;
                    push.r0   = gdd_pkg::mk_err(gdd_pkg::ERR_VARINT_LEN, fin);
                    restart   = fin;
                    hold_err  = !fin;
                    hold_code = gdd_pkg::ERR_VARINT_LEN;
                end
                else if (c[7])
                begin
                    varint_next = vnew;
                    shift_next  = shift_reg + gdd_pkg::SHIFT_STEP;
                    if (fin)
                    begin
                        push.n  = 2'd1;
                        push.r0 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                        restart = 1'b1;
                    end
                end
                else
                begin
                    varint_next = '0;
                    shift_next  = '0;
                    if (phase_reg == gdd_pkg::PH_SRC)
                    begin
                        if (cmp_val != cmp_base)
                        begin
                            push.n    = 2'd1;
                            push.r0   = gdd_pkg::mk_err(gdd_pkg::ERR_SRC_SIZE, fin);
                            restart   = fin;
                            hold_err  = !fin;
                            hold_code = gdd_pkg::ERR_SRC_SIZE;
                        end
                        else
                        begin
                            phase_next = gdd_pkg::PH_TGT;
                            if (fin)
                            begin
                                push.n  = 2'd1;
                                push.r0 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                                restart = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        target_next = vnew;
                        phase_next  = gdd_pkg::PH_OP;
                        if (fin)
                        begin
                            // empty instruction list: produced count is zero here
                            push.n  = 2'd1;
                            push.r0 = (produced_reg == vnew_ext) ? gdd_pkg::mk_done()
                                    : gdd_pkg::mk_err(gdd_pkg::ERR_TGT_SIZE, 1'b1);
                            restart = 1'b1;
                        end
                    end
                end
            end
            gdd_pkg::PH_OP:
            begin
                if (c[7])
                begin
                    pend_next = c[6:0];
                    off_next  = '0;
                    len_next  = '0;
                    if (c[6:0] == 7'd0)
                    begin
                        do_copy = 1'b1;
                    end
                    else
                    begin
                        phase_next = gdd_pkg::PH_ARGS;
                        if (fin)
                        begin
                            push.n  = 2'd1;
                            push.r0 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                            restart = 1'b1;
                        end
                    end
                end
                else if (c != 8'd0)
                begin
                    lit_rem_next = c[6:0];
                    phase_next   = gdd_pkg::PH_LIT;
                    if (fin)
                    begin
                        push.n  = 2'd1;
                        push.r0 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                        restart = 1'b1;
                    end
                end
                else
                begin
                    push.n    = 2'd1;
                    push.r0   = gdd_pkg::mk_err(gdd_pkg::ERR_OPCODE_0, fin);
                    restart   = fin;
                    hold_err  = !fin;
                    hold_code = gdd_pkg::ERR_OPCODE_0;
                end
            end
            gdd_pkg::PH_ARGS:
            begin
                off_next  = off_upd;
                len_next  = len_upd;
                pend_next = pend_upd;
                if (pend_upd != 7'd0)
                begin
                    if (fin)
                    begin
                        push.n  = 2'd1;
                        push.r0 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                        restart = 1'b1;
                    end
                end
                else
                begin
                    do_copy = 1'b1;
                end
            end
            gdd_pkg::PH_LIT:
            begin
                push.n        = 2'd1;
                push.r0       = gdd_pkg::mk_lit(c);
                produced_next = prod_lit;
                lit_rem_next  = lit_rem_reg - 7'd1;
                if (lit_rem_reg == 7'd1)
                begin
                    phase_next = gdd_pkg::PH_OP;
                    if (fin)
                    begin
                        push.n  = 2'd2;
                        push.r1 = (prod_lit == target_ext) ? gdd_pkg::mk_done()
                                : gdd_pkg::mk_err(gdd_pkg::ERR_TGT_SIZE, 1'b1);
                        restart = 1'b1;
                    end
                end
                else if (fin)
                begin
                    // cut-off literal: byte first, then the truncation error
                    push.n  = 2'd2;
                    push.r1 = gdd_pkg::mk_err(gdd_pkg::ERR_TRUNCATED, 1'b1);
                    restart = 1'b1;
                end
            end
            gdd_pkg::PH_ERR:
            begin
                if (fin)
                begin
                    push.n  = 2'd1;
                    push.r0 = gdd_pkg::mk_err(err_code_reg, 1'b1);
                    restart = 1'b1;
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        if (do_copy)
        begin
            pend_next = 7'd0;
            if (cc_beyond)
            begin
                push.n    = 2'd1;
                push.r0   = gdd_pkg::mk_err(gdd_pkg::ERR_COPY_RANGE, fin);
                restart   = fin;
                hold_err  = !fin;
                hold_code = gdd_pkg::ERR_COPY_RANGE;
            end
            else
            begin
                push.n        = 2'd1;
                push.r0       = gdd_pkg::mk_copy(cc_off, cc_len);
                produced_next = prod_copy;
                phase_next    = gdd_pkg::PH_OP;
                if (fin)
                begin
                    push.n  = 2'd2;
                    push.r1 = (prod_copy == target_ext) ? gdd_pkg::mk_done()
                            : gdd_pkg::mk_err(gdd_pkg::ERR_TGT_SIZE, 1'b1);
                    restart = 1'b1;
                end
            end
        end

        if (hold_err)
        begin
            phase_next    = gdd_pkg::PH_ERR;
            err_code_next = hold_code;
        end

        if (restart)
        begin
            phase_next    = gdd_pkg::PH_SRC;
            varint_next   = '0;
            shift_next    = '0;
            target_next   = '0;
            produced_next = '0;
            pend_next     = '0;
            off_next      = '0;
            len_next      = '0;
            lit_rem_next  = '0;
            err_code_next = gdd_pkg::ERR_NONE;
        end

        if (!fire)
        begin
            push          = '0;
            phase_next    = phase_reg;
            varint_next   = varint_reg;
            shift_next    = shift_reg;
            target_next   = target_reg;
            produced_next = produced_reg;
            pend_next     = pend_reg;
            off_next      = off_reg;
            len_next      = len_reg;
            lit_rem_next  = lit_rem_reg;
            err_code_next = err_code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= delta_byte;
            last_in_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            base_size_reg  <= '0;
            phase_reg      <= gdd_pkg::PH_SRC;
            varint_reg     <= '0;
            shift_reg      <= '0;
            target_reg     <= '0;
            produced_reg   <= '0;
            pend_reg       <= '0;
            off_reg        <= '0;
            len_reg        <= '0;
            lit_rem_reg    <= '0;
            err_code_reg   <= gdd_pkg::ERR_NONE;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_valid)
            begin
                base_size_reg <= base_size;
            end
            phase_reg    <= phase_next;
            varint_reg   <= varint_next;
            shift_reg    <= shift_next;
            target_reg   <= target_next;
            produced_reg <= produced_next;
            pend_reg     <= pend_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            lit_rem_reg  <= lit_rem_next;
            err_code_reg <= err_code_next;
        end
    end

endmodule

// ===== hdl/git_delta_instruction_decoder_top.sv =====
// top level of the git pack delta instruction decoder
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | base_size
//  in      | in        | in_valid/in_ready    | delta_byte, last_byte
//  out     | out       | out_valid/out_ready  | kind, literal_byte, copy_offset,
//          |           |                      | copy_length, error_code, last
//
// one delta byte per cycle while each byte gives at most one result and out_ready stays
// high; a byte that gives two results hands them to the output port one after the other
// each result passes the input register and then the queue before it reaches the output
// the four-entry result queue sets the pace: a byte is decoded only with two slots free
// reset clears stream state, base_size and the queue; no clearing pass is needed
// cfg_ready is always high; base_size takes effect on the next decoded byte
`timescale 1ns / 1ps

`include "git_delta_instruction_decoder_top_defines.svh"

module git_delta_instruction_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] base_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  delta_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  literal_byte,
    output logic [31:0] copy_offset,
    output logic [23:0] copy_length,
    output logic [2:0]  error_code,
    output logic        last
);

    gdd_pkg::push_t      push;
    gdd_pkg::fifo_stat_t fifo_stat;
    gdd_pkg::result_t    head;

    assign cfg_ready = 1'b1;

    gdd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .base_size  (base_size),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .delta_byte (delta_byte),
        .last_byte  (last_byte),
        .fifo_stat  (fifo_stat),
        .push       (push)
    );

    gdd_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .stat      (fifo_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign literal_byte = head.literal_byte;
    assign copy_offset  = head.copy_offset;
    assign copy_length  = head.copy_length;
    assign error_code   = head.error_code;
    assign last         = head.last;

    // a stream always closes with a done or an error result
    `GDD_ASSERT_IMPL(a_last_kind, out_valid && last, kind == gdd_pkg::KIND_DONE || kind == gdd_pkg::KIND_ERR)
    // done carries no error and ends the stream
    `GDD_ASSERT_IMPL(a_done_clean, out_valid && kind == gdd_pkg::KIND_DONE, error_code == gdd_pkg::ERR_NONE && last)
    // the queue never overfills, since a byte is decoded only with two slots free
    `GDD_ASSERT_IMPL(a_fifo_bound, push.n != 2'd0, fifo_stat.space)
    // a transfer with nothing pushed frees one slot
    `GDD_ASSERT_NEXT(a_pop_count, out_valid && out_ready && push.n == 2'd0, fifo_stat.count == $past(fifo_stat.count) - 1'b1)

endmodule
